[rtl/modular_arithmetic_unit_defines.svh]
// Assertion macros shared by the modular arithmetic unit RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// Property holds at every edge outside reset.
`define MAU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("modular_arithmetic_unit: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define MAU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("modular_arithmetic_unit: sequence assertion failed");

`endif

[rtl/mau_pkg.sv]
// Package for the modular arithmetic unit: field widths, prime constants,
// Montgomery constants, shared types and the sequencer microcode table. No dependencies.
package mau_pkg;

   localparam int MauOpW  = 3;
   localparam int MauResW = 30;
   localparam int MauExpW = 31;

   localparam logic [MauResW-1:0] MauModP   = 30'd1000000007;
   localparam logic [MauExpW-1:0] MauExpInv = 31'd1000000005;
   // R = 2**30; R mod P is the Montgomery form of one
   localparam logic [MauResW-1:0] MauRModP  = 30'd73741817;
   localparam logic [63:0] MauR2Wide =
      (64'(MauRModP) * 64'(MauRModP)) % 64'(MauModP);
   localparam logic [MauResW-1:0] MauR2 = MauR2Wide[MauResW-1:0];

   // -P^-1 mod 2**30 by Newton iteration, evaluated at elaboration only
   function automatic logic [MauResW-1:0] mau_neg_pinv();
      logic [31:0] x;
      x = 32'(MauModP);
      for (int i = 0; i < 4; i++) begin
         x = x * (32'd2 - 32'(MauModP) * x);
      end
      x = ~x + 32'd1;
      return x[MauResW-1:0];
   endfunction

   localparam logic [MauResW-1:0] MauPInv = mau_neg_pinv();

   typedef enum logic [MauOpW-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_NEG = 3'd3,
      OP_INV = 3'd4,
      OP_DIV = 3'd5,
      OP_POW = 3'd6
   } mau_op_type;

   typedef enum logic {
      DEST_BASE,
      DEST_ACC
   } mau_dest_type;

   typedef struct packed {
      logic                valid;
      logic [MauResW-1:0]  a;
      logic [MauResW-1:0]  b;
      mau_dest_type        dest;
   } mau_mul_req_type;

   typedef struct packed {
      logic                valid;
      logic [MauResW-1:0]  res;
      mau_dest_type        dest;
   } mau_mul_rsp_type;

   // Microcode
   typedef logic [2:0] mau_upc_type;

   localparam mau_upc_type UpcConv  = 3'd0;
   localparam mau_upc_type UpcLoop  = 3'd1;
   localparam mau_upc_type UpcMul   = 3'd2;
   localparam mau_upc_type UpcSqr   = 3'd3;
   localparam mau_upc_type UpcFinal = 3'd4;

   typedef enum logic [1:0] {
      ISSUE_NONE,
      ISSUE_ALWAYS,
      ISSUE_IF_BIT
   } mau_issue_type;

   typedef enum logic {
      ASEL_BASE,
      ASEL_ACC
   } mau_asel_type;

   typedef enum logic [1:0] {
      BSEL_BASE,
      BSEL_R2,
      BSEL_FIN
   } mau_bsel_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_EXP_ZERO
   } mau_jump_type;

   typedef struct packed {
      mau_issue_type issue;
      mau_asel_type  a_sel;
      mau_bsel_type  b_sel;
      mau_dest_type  dest;
      logic          shift_exp;
      logic          wait_drain;
      mau_jump_type  jump;
      mau_upc_type   target;
      logic          done;
   } mau_uword_type;

   // Square-and-multiply program over Montgomery residues
   function automatic mau_uword_type mau_ucode(input mau_upc_type upc);
      mau_uword_type w;
      w = '{issue: ISSUE_NONE, a_sel: ASEL_BASE, b_sel: BSEL_BASE, dest: DEST_BASE,
            shift_exp: 1'b0, wait_drain: 1'b0, jump: JMP_NONE, target: UpcConv,
            done: 1'b0};
      unique case (upc)
         UpcConv: begin
            // base = mont(base, R^2): into Montgomery form
            w.issue      = ISSUE_ALWAYS;
            w.b_sel      = BSEL_R2;
            w.wait_drain = 1'b1;
         end
         UpcLoop: begin
            w.jump   = JMP_EXP_ZERO;
            w.target = UpcFinal;
         end
         UpcMul: begin
            w.issue = ISSUE_IF_BIT;
            w.a_sel = ASEL_ACC;
            w.dest  = DEST_ACC;
         end
         UpcSqr: begin
            w.issue      = ISSUE_ALWAYS;
            w.shift_exp  = 1'b1;
            w.wait_drain = 1'b1;
            w.jump       = JMP_ALWAYS;
            w.target     = UpcLoop;
         end
         UpcFinal: begin
            // acc = mont(acc, fin): leave Montgomery form, scale by fin
            w.issue      = ISSUE_ALWAYS;
            w.a_sel      = ASEL_ACC;
            w.b_sel      = BSEL_FIN;
            w.dest       = DEST_ACC;
            w.wait_drain = 1'b1;
            w.done       = 1'b1;
         end
         default: begin
            w.jump   = JMP_ALWAYS;
            w.target = UpcFinal;
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/mau_req_if.sv]
// Request channel of the modular arithmetic unit: valid/ready plus operands.
// Depends on mau_pkg for field widths.
interface mau_req_if;
   logic                        valid;
   logic                        ready;
   logic [mau_pkg::MauOpW-1:0]  req_type;
   logic [mau_pkg::MauResW-1:0] operand_a;
   logic [mau_pkg::MauResW-1:0] operand_b;
   logic [mau_pkg::MauExpW-1:0] exponent;

   modport source (output valid, req_type, operand_a, operand_b, exponent, input ready);
   modport sink   (input valid, req_type, operand_a, operand_b, exponent, output ready);
endinterface

[rtl/mau_rsp_if.sv]
// Response channel of the modular arithmetic unit: valid/ready plus result.
// Depends on mau_pkg for field widths.
interface mau_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mau_pkg::MauResW-1:0] result;
   logic                        zero_inverse_error;

   modport source (output valid, result, zero_inverse_error, input ready);
   modport sink   (input valid, result, zero_inverse_error, output ready);
endinterface

[rtl/mau_mont.sv]
// Four-stage Montgomery multiplier, R = 2**30, modulus P = 1000000007.
// Depends on mau_pkg and modular_arithmetic_unit_defines.svh.
`include "modular_arithmetic_unit_defines.svh"

module mau_mont (
   input  logic                     clock,
   input  logic                     reset,
   input  mau_pkg::mau_mul_req_type mul_req,
   output mau_pkg::mau_mul_rsp_type mul_rsp,
   output logic                     busy
);

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   mau_pkg::mau_dest_type tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [59:0]          prod_ff, prod_in;
   logic [59:0]          t2_ff;
   logic [29:0]          m_ff, m_in;
   logic [59:0]          mq_prod;
   logic [59:0]          mp;
   logic [60:0]          sum;
   logic [30:0]          u_ff, u_in;
   logic [29:0]          r_ff, r_in;

   assign prod_in = {30'd0, mul_req.a} * {30'd0, mul_req.b};
   // m = (T mod R) * (-P^-1) mod R
   assign mq_prod = {30'd0, prod_ff[29:0]} * {30'd0, mau_pkg::MauPInv};
   assign m_in    = mq_prod[29:0];
   // (T + m*P) is a multiple of R
   assign mp      = {30'd0, m_ff} * {30'd0, mau_pkg::MauModP};
   assign sum     = {1'b0, t2_ff} + {1'b0, mp};
   assign u_in    = sum[60:30];
   assign r_in    = (u_ff >= {1'b0, mau_pkg::MauModP}) ?
                    30'(u_ff - {1'b0, mau_pkg::MauModP}) : u_ff[29:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= mul_req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      prod_ff <= prod_in;
      tag1_ff <= mul_req.dest;
      t2_ff   <= prod_ff;
      m_ff    <= m_in;
      tag2_ff <= tag1_ff;
      u_ff    <= u_in;
      tag3_ff <= tag2_ff;
      r_ff    <= r_in;
      tag4_ff <= tag3_ff;
   end

   assign mul_rsp.valid = v4_ff;
   assign mul_rsp.res   = r_ff;
   assign mul_rsp.dest  = tag4_ff;
   assign busy          = v1_ff | v2_ff | v3_ff | v4_ff;

   `MAU_ASSERT(a_redc_exact, v2_ff |-> (sum[29:0] == 30'd0))
   `MAU_ASSERT(a_res_canon, v4_ff |-> (r_ff < mau_pkg::MauModP))
   `MAU_ASSERT_NEXT(a_pipe_advance, v3_ff, v4_ff)

endmodule

[rtl/modular_arithmetic_unit.sv]
// Modular arithmetic unit over P = 1000000007, one transaction at a time.
// Add, sub, negate, undefined codes, zero-divisor errors: result set in EXEC, output from DONE.
// Multiply, inverse, divide and power go through RUN; power time grows with exponent bit length.
// Exponent bits are consumed in turn: the microcode drains the 4-stage Montgomery multiplier
// once per bit. The next request is taken the cycle after the result registers.
// Synchronous reset clears control only.
`include "modular_arithmetic_unit_defines.svh"

module modular_arithmetic_unit (
   input logic       clock,
   input logic       reset,
   mau_req_if.sink   req_if,
   mau_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   mau_pkg::mau_op_type     op_ff, op_in;
   logic [29:0]             a_ff, a_in, b_ff, b_in;
   logic [30:0]             exp_ff, exp_in;
   logic [29:0]             base_ff, base_in, acc_ff, acc_in, fin_ff, fin_in;
   mau_pkg::mau_upc_type    upc_ff, upc_in;
   logic                    issued_ff, issued_in;
   logic [29:0]             pend_res_ff, pend_res_in;
   logic                    pend_err_ff, pend_err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [29:0]             rsp_result_ff, rsp_result_in;
   logic                    rsp_err_ff, rsp_err_in;

   mau_pkg::mau_uword_type   uw;
   mau_pkg::mau_mul_req_type mul_req;
   mau_pkg::mau_mul_rsp_type mul_rsp;
   logic                     mul_busy;
   logic                     step_done;
   logic [30:0]              add_sum, sub_wrap;
   logic [29:0]              add_res, sub_res, neg_res;
   logic                     div_inv_op;

   function automatic logic [29:0] canon(input logic [29:0] x);
      return (x >= mau_pkg::MauModP) ? x - mau_pkg::MauModP : x;
   endfunction

   mau_mont u_mont (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp),
      .busy    (mul_busy)
   );

   assign uw = mau_pkg::mau_ucode(upc_ff);

   assign add_sum  = {1'b0, a_ff} + {1'b0, b_ff};
   assign add_res  = (add_sum >= {1'b0, mau_pkg::MauModP}) ?
                     30'(add_sum - {1'b0, mau_pkg::MauModP}) : add_sum[29:0];
   assign sub_wrap = {1'b0, a_ff} + {1'b0, mau_pkg::MauModP} - {1'b0, b_ff};
   assign sub_res  = (a_ff >= b_ff) ? a_ff - b_ff : sub_wrap[29:0];
   assign neg_res  = (a_ff == 30'd0) ? 30'd0 : mau_pkg::MauModP - a_ff;

   // Multiplier issue from the current control word
   always_comb begin
      mul_req.valid = (state_ff == ST_RUN) && !issued_ff &&
                      ((uw.issue == mau_pkg::ISSUE_ALWAYS) ||
                       (uw.issue == mau_pkg::ISSUE_IF_BIT && exp_ff[0]));
      mul_req.a     = (uw.a_sel == mau_pkg::ASEL_ACC) ? acc_ff : base_ff;
      unique case (uw.b_sel)
         mau_pkg::BSEL_R2:  mul_req.b = mau_pkg::MauR2;
         mau_pkg::BSEL_FIN: mul_req.b = fin_ff;
         default:           mul_req.b = base_ff;
      endcase
      mul_req.dest  = uw.dest;
   end

   // A waiting step ends once every issued product is written back
   assign step_done = issued_ff ? !mul_busy : !uw.wait_drain;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      exp_in        = exp_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      fin_in        = fin_ff;
      upc_in        = upc_ff;
      issued_in     = issued_ff;
      pend_res_in   = pend_res_ff;
      pend_err_in   = pend_err_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_err_in    = rsp_err_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (mul_rsp.valid) begin
         if (mul_rsp.dest == mau_pkg::DEST_BASE) begin
            base_in = mul_rsp.res;
         end else begin
            acc_in = mul_rsp.res;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in    = mau_pkg::mau_op_type'(req_if.req_type);
               a_in     = canon(req_if.operand_a);
               b_in     = canon(req_if.operand_b);
               exp_in   = req_if.exponent;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            pend_res_in = 30'd0;
            pend_err_in = 1'b0;
            state_in    = ST_DONE;
            upc_in      = mau_pkg::UpcConv;
            issued_in   = 1'b0;
            acc_in      = mau_pkg::MauRModP;
            base_in     = a_ff;
            fin_in      = 30'd1;
            unique case (op_ff)
               mau_pkg::OP_ADD: pend_res_in = add_res;
               mau_pkg::OP_SUB: pend_res_in = sub_res;
               mau_pkg::OP_NEG: pend_res_in = neg_res;
               mau_pkg::OP_MUL: begin
                  fin_in   = b_ff;
                  exp_in   = 31'd1;
                  state_in = ST_RUN;
               end
               mau_pkg::OP_INV: begin
                  if (a_ff == 30'd0) begin
                     pend_err_in = 1'b1;
                  end else begin
                     exp_in   = mau_pkg::MauExpInv;
                     state_in = ST_RUN;
                  end
               end
               mau_pkg::OP_DIV: begin
                  if (b_ff == 30'd0) begin
                     pend_err_in = 1'b1;
                  end else begin
                     base_in  = b_ff;
                     fin_in   = a_ff;
                     exp_in   = mau_pkg::MauExpInv;
                     state_in = ST_RUN;
                  end
               end
               mau_pkg::OP_POW: state_in = ST_RUN;
               default: ;
            endcase
         end
         ST_RUN: begin
            if (!issued_ff && uw.shift_exp) begin
               exp_in = exp_ff >> 1;
            end
            if (!step_done) begin
               issued_in = 1'b1;
            end else begin
               issued_in = 1'b0;
               priority if (uw.done) begin
                  pend_res_in = acc_ff;
                  pend_err_in = 1'b0;
                  state_in    = ST_DONE;
               end else if (uw.jump == mau_pkg::JMP_ALWAYS ||
                            (uw.jump == mau_pkg::JMP_EXP_ZERO && exp_ff == 31'd0)) begin
                  upc_in = uw.target;
               end else begin
                  upc_in = upc_ff + 3'd1;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = pend_res_ff;
               rsp_err_in    = pend_err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         upc_ff       <= mau_pkg::UpcConv;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upc_ff       <= upc_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      exp_ff        <= exp_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      fin_ff        <= fin_in;
      pend_res_ff   <= pend_res_in;
      pend_err_ff   <= pend_err_in;
      rsp_result_ff <= rsp_result_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign req_if.ready              = (state_ff == ST_IDLE);
   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.result             = rsp_result_ff;
   assign rsp_if.zero_inverse_error = rsp_err_ff;

   assign div_inv_op = (op_ff == mau_pkg::OP_INV) || (op_ff == mau_pkg::OP_DIV);

   `MAU_ASSERT(a_issue_in_run, mul_req.valid |-> (state_ff == ST_RUN))
   `MAU_ASSERT(a_writeback_in_run, mul_rsp.valid |-> (state_ff == ST_RUN))
   `MAU_ASSERT(a_err_only_div_inv, (state_ff == ST_DONE && pend_err_ff) |-> div_inv_op)

endmodule
